/* rtl/enfa_pkg.sv */
// ----------------------------------------------------------------------------
// enfa_pkg
// Shared widths, types and codes for the epsilon-NFA recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package enfa_pkg;

  // Automaton size
  localparam int NUM_STATES   = 16;
  localparam int SYMBOL_BITS  = 8;
  localparam int IDX_W        = $clog2(NUM_STATES);
  localparam int ADDR_W       = IDX_W + SYMBOL_BITS;
  localparam int ROW_COUNT    = NUM_STATES << SYMBOL_BITS;

  // Fixed field widths of the channels
  localparam int OP_W         = 2;
  localparam int STATE_FLD_W  = 4;
  localparam int SYMBOL_FLD_W = 8;
  localparam int MASK_W       = 16;

  // Configuration port
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_STATE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_STATE   = 1'd1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_SYM = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_EPS = 2'd1;
  localparam logic [OP_W-1:0] OP_START    = 2'd2;
  localparam logic [OP_W-1:0] OP_FEED     = 2'd3;

  typedef logic [NUM_STATES-1:0] state_set_t;
  typedef logic [ADDR_W-1:0]     row_addr_t;

  // Engine request to the symbol-move table
  typedef struct packed {
    logic       we;
    logic       re;
    row_addr_t  addr;
    state_set_t wdata;
  } symtab_req_t;

  // Finished result from the engine
  typedef struct packed {
    logic       valid;
    state_set_t set;
  } result_t;

endpackage

`default_nettype wire

/* rtl/enfa_in_if.sv */
// ----------------------------------------------------------------------------
// enfa_in_if
// Input channel: operation words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface enfa_in_if;
  logic                                valid;
  logic                                ready;
  logic [enfa_pkg::OP_W-1:0]           operation;
  logic [enfa_pkg::STATE_FLD_W-1:0]    state_index;
  logic [enfa_pkg::SYMBOL_FLD_W-1:0]   symbol;
  logic [enfa_pkg::MASK_W-1:0]         target_mask;

  modport source (output valid, operation, state_index, symbol, target_mask,
                  input ready);
  modport sink   (input valid, operation, state_index, symbol, target_mask,
                  output ready);
endinterface

`default_nettype wire

/* rtl/enfa_out_if.sv */
// ----------------------------------------------------------------------------
// enfa_out_if
// Output channel: active-set words with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface enfa_out_if;
  logic                        valid;
  logic                        ready;
  logic [enfa_pkg::MASK_W-1:0] active_set;
  logic                        accepting;

  modport source (output valid, active_set, accepting, input ready);
  modport sink   (input valid, active_set, accepting, output ready);
endinterface

`default_nettype wire

/* rtl/epsilon_nfa_recognizer_top.sv */
// ----------------------------------------------------------------------------
// epsilon_nfa_recognizer_top
// Epsilon-NFA recognizer over a byte stream with loadable move tables.
//
//   Channel   Dir  Handshake          Word
//   in_ch     in   valid/ready        operation, state_index, symbol, target_mask
//   out_ch    out  valid/ready        active_set, accepting
//   cfg       in   cfg_we (no wait)   cfg_index, cfg_data
//
// Load words are written as they are taken. A start word runs closure sweeps
// from the initial state, a feed word closure sweeps, the symbol step and
// closure sweeps again; the closure walks one state per cycle through one OR
// unit. After reset a clear sweep over all 4096 rows zeroes the symbol table;
// in_ch is not ready meanwhile. A result waits in the output register while
// the next word is taken; the engine holds its result if that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module epsilon_nfa_recognizer_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [enfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [enfa_pkg::CFG_DATA_W-1:0]    cfg_data,
  enfa_in_if.sink                                 in_ch,
  enfa_out_if.source                              out_ch
);

  logic [enfa_pkg::CFG_DATA_W-1:0] initial_state;
  logic [enfa_pkg::CFG_DATA_W-1:0] final_state;

  enfa_pkg::symtab_req_t           sym_req;
  enfa_pkg::state_set_t            sym_rd_data;
  logic                            sym_clearing;
  enfa_pkg::result_t               res;
  logic                            res_take;

  logic                            out_valid;
  logic [enfa_pkg::MASK_W-1:0]     out_set;
  logic                            out_accepting;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_state <= '0;
      final_state   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        enfa_pkg::CFG_INITIAL_STATE: initial_state <= cfg_data;
        enfa_pkg::CFG_FINAL_STATE:   final_state   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  enfa_symtab u_symtab (
    .clk      (clk),
    .rst      (rst),
    .req      (sym_req),
    .rd_data  (sym_rd_data),
    .clearing (sym_clearing)
  );

  enfa_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .in_ch         (in_ch),
    .initial_state (initial_state),
    .sym_req       (sym_req),
    .sym_rd_data   (sym_rd_data),
    .sym_clearing  (sym_clearing),
    .res           (res),
    .res_take      (res_take)
  );

  // Output register: load when empty or being drained
  assign res_take = res.valid && (!out_valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_set       <= enfa_pkg::MASK_W'(res.set);
      out_accepting <= (int'(final_state) < enfa_pkg::NUM_STATES)
                       && res.set[enfa_pkg::IDX_W'(final_state)];
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.active_set = out_set;
  assign out_ch.accepting  = out_accepting;

endmodule

`default_nettype wire

/* rtl/enfa_symtab.sv */
// ----------------------------------------------------------------------------
// enfa_symtab
// Symbol-move table: one row per (state, symbol), cleared by a sweep after
// reset, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_symtab (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire enfa_pkg::symtab_req_t  req,
  output enfa_pkg::state_set_t        rd_data,
  output logic                        clearing
);

  enfa_pkg::state_set_t mem [enfa_pkg::ROW_COUNT];
  enfa_pkg::row_addr_t  clr_addr;

  // Sweep the table to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == enfa_pkg::ADDR_W'(enfa_pkg::ROW_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port: clear sweep or row load
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

  // No engine access while the sweep runs
  a_no_access_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> (!req.re && !req.we))
    else $error("symbol table accessed during clear sweep");

endmodule

`default_nettype wire

/* rtl/enfa_engine.sv */
// ----------------------------------------------------------------------------
// enfa_engine
// Sequencer and shared OR unit: loads the tables, walks the epsilon closure
// one state per cycle and gathers symbol moves one table row per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_engine (
  input  wire logic                              clk,
  input  wire logic                              rst,
  enfa_in_if.sink                                in_ch,
  input  wire logic [enfa_pkg::CFG_DATA_W-1:0]   initial_state,
  output enfa_pkg::symtab_req_t                  sym_req,
  input  wire enfa_pkg::state_set_t              sym_rd_data,
  input  wire logic                              sym_clearing,
  output enfa_pkg::result_t                      res,
  input  wire logic                              res_take
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CLOS = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [enfa_pkg::IDX_W-1:0] LAST_IDX =
    enfa_pkg::IDX_W'(enfa_pkg::NUM_STATES - 1);

  logic [1:0]                          state;
  enfa_pkg::state_set_t                cur;
  enfa_pkg::state_set_t                eps [enfa_pkg::NUM_STATES];
  enfa_pkg::state_set_t                acc;
  logic [enfa_pkg::IDX_W-1:0]          idx;
  logic [enfa_pkg::SYMBOL_BITS-1:0]    sym;
  logic                                pre;
  logic                                changed;
  logic                                take_d;
  logic                                last_d;

  logic                                in_acc;
  logic                                idx_in_range;
  logic [enfa_pkg::IDX_W-1:0]          in_idx;
  logic [enfa_pkg::SYMBOL_BITS-1:0]    in_sym;
  enfa_pkg::state_set_t                in_mask;
  enfa_pkg::state_set_t                start_set;
  enfa_pkg::state_set_t                cur_next;
  logic                                grew;

  // Handshake and input decode
  assign in_ch.ready  = (state == S_IDLE) && !sym_clearing;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign idx_in_range = int'(in_ch.state_index) < enfa_pkg::NUM_STATES;
  assign in_idx       = enfa_pkg::IDX_W'(in_ch.state_index);
  assign in_sym       = in_ch.symbol[enfa_pkg::SYMBOL_BITS-1:0];
  assign in_mask      = enfa_pkg::state_set_t'(in_ch.target_mask);
  assign start_set    = (int'(initial_state) < enfa_pkg::NUM_STATES)
                        ? (enfa_pkg::state_set_t'(1) << enfa_pkg::IDX_W'(initial_state))
                        : '0;

  // Shared OR unit: add the epsilon row of the visited state
  assign cur_next = cur[idx] ? (cur | eps[idx]) : cur;
  assign grew     = (cur_next != cur);

  // Table requests: row load in idle, row reads during the symbol step
  always_comb begin
    sym_req.we    = in_acc && (in_ch.operation == enfa_pkg::OP_LOAD_SYM) && idx_in_range;
    sym_req.re    = (state == S_STEP);
    sym_req.addr  = sym_req.we ? {in_idx, in_sym} : {idx, sym};
    sym_req.wdata = in_mask;
  end

  assign res.valid = (state == S_DONE);
  assign res.set   = cur;

  // Control state and epsilon table
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= '0;
      for (int i = 0; i < enfa_pkg::NUM_STATES; i++) begin
        eps[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.operation)
              enfa_pkg::OP_LOAD_SYM: begin
              end
              enfa_pkg::OP_LOAD_EPS: begin
                if (idx_in_range) begin
                  eps[in_idx] <= in_mask;
                end
              end
              enfa_pkg::OP_START: begin
                cur   <= start_set;
                state <= S_CLOS;
              end
              enfa_pkg::OP_FEED: begin
                state <= S_CLOS;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLOS: begin
          cur <= cur_next;
          if (idx == LAST_IDX && !changed && !grew) begin
            state <= pre ? S_STEP : S_DONE;
          end
        end
        S_STEP: begin
          if (last_d) begin
            cur   <= acc | (take_d ? sym_rd_data : '0);
            state <= S_CLOS;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        idx     <= '0;
        changed <= 1'b0;
        sym     <= in_sym;
        pre     <= (in_ch.operation == enfa_pkg::OP_FEED);
      end
      S_CLOS: begin
        acc    <= '0;
        take_d <= 1'b0;
        last_d <= 1'b0;
        if (idx == LAST_IDX) begin
          idx     <= '0;
          changed <= 1'b0;
        end else begin
          idx     <= idx + 1'b1;
          changed <= changed | grew;
        end
      end
      S_STEP: begin
        // Issue one row read, fold in the row read the cycle before
        take_d <= cur[idx];
        last_d <= (idx == LAST_IDX);
        if (take_d) begin
          acc <= acc | sym_rd_data;
        end
        if (last_d) begin
          pre     <= 1'b0;
          idx     <= '0;
          changed <= 1'b0;
        end else begin
          idx <= (idx == LAST_IDX) ? '0 : idx + 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  a_take_only_when_done: assert property (
    @(posedge clk) disable iff (rst) res_take |-> (state == S_DONE))
    else $error("result taken while engine not done");

  a_feed_starts_closure: assert property (
    @(posedge clk) disable iff (rst)
    (in_acc && in_ch.operation == enfa_pkg::OP_FEED) |=> (state == S_CLOS && pre))
    else $error("feed word did not start pre-step closure");

  a_closure_grows: assert property (
    @(posedge clk) disable iff (rst)
    (state == S_CLOS && $past(state) == S_CLOS) |-> ((cur & $past(cur)) == $past(cur)))
    else $error("closure dropped an active state");

endmodule

`default_nettype wire

/* tb/enfa_active_set_checker.sv */
// ----------------------------------------------------------------------------
// enfa_active_set_checker
// Watches the word channels and the register port of the epsilon-NFA
// recognizer, keeps its own copy of both move tables, the registers and the
// active set, predicts the result of every start and feed word, and compares
// each result word against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module enfa_active_set_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [enfa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [enfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  enfa_in_if                                    in_ch,
  enfa_out_if                                   out_ch,
  output int                                    fail_count,
  output int                                    pending_count,
  output int                                    result_count
);
  import enfa_pkg::*;

  typedef struct packed {
    logic [MASK_W-1:0] active_set;
    logic              accepting;
  } set_word_t;

  // Model state of the automaton
  state_set_t             sym_moves [ROW_COUNT];
  state_set_t             eps_moves [NUM_STATES];
  state_set_t             live_set;
  logic [CFG_DATA_W-1:0]  start_state;
  logic [CFG_DATA_W-1:0]  accept_state;

  set_word_t              expected_sets [$];
  set_word_t              oldest;
  int                     mismatches;
  int                     results_seen;

  // Row of the symbol table for a source state and an input byte
  function automatic int row_of(int src, logic [SYMBOL_FLD_W-1:0] sym);
    return src * (1 << SYMBOL_BITS) + (int'(sym) & ((1 << SYMBOL_BITS) - 1));
  endfunction

  // Grow a set along epsilon moves until it stops changing
  function automatic state_set_t eps_closure(state_set_t seed);
    state_set_t cur;
    state_set_t nxt;
    cur = seed;
    for (int round = 0; round <= NUM_STATES; round++) begin
      nxt = cur;
      for (int s = 0; s < NUM_STATES; s++) begin
        if (cur[s]) nxt |= eps_moves[s];
      end
      if (nxt == cur) break;
      cur = nxt;
    end
    return cur;
  endfunction

  // Union of the symbol moves out of every active state
  function automatic state_set_t step_on_symbol(state_set_t set, logic [SYMBOL_FLD_W-1:0] sym);
    state_set_t reached;
    reached = '0;
    for (int s = 0; s < NUM_STATES; s++) begin
      if (set[s]) reached |= sym_moves[row_of(s, sym)];
    end
    return reached;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) sym_moves[r] = '0;
      for (int s = 0; s < NUM_STATES; s++) eps_moves[s] = '0;
      live_set     = '0;
      start_state  = '0;
      accept_state = '0;
      expected_sets.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_INITIAL_STATE: start_state  = cfg_data;
          CFG_FINAL_STATE:   accept_state = cfg_data;
          default: ;
        endcase
      end

      // Compare a result word with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_sets.size() == 0) begin
          mismatches++;
          $error("active_set unexpected: expected no word, actual %h", out_ch.active_set);
        end else begin
          oldest = expected_sets.pop_front();
          if (out_ch.active_set !== oldest.active_set) begin
            mismatches++;
            $error("active_set mismatch: expected %h, actual %h",
                   oldest.active_set, out_ch.active_set);
          end
          if (out_ch.accepting !== oldest.accepting) begin
            mismatches++;
            $error("accepting mismatch: expected %b, actual %b",
                   oldest.accepting, out_ch.accepting);
          end
        end
      end

      // Apply an accepted input word to the model
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.operation)
          OP_LOAD_SYM: begin
            if (in_ch.state_index < NUM_STATES)
              sym_moves[row_of(int'(in_ch.state_index), in_ch.symbol)] =
                state_set_t'(in_ch.target_mask);
          end
          OP_LOAD_EPS: begin
            if (in_ch.state_index < NUM_STATES)
              eps_moves[in_ch.state_index] = state_set_t'(in_ch.target_mask);
          end
          OP_START, OP_FEED: begin
            if (in_ch.operation == OP_START) begin
              if (start_state < NUM_STATES)
                live_set = eps_closure(state_set_t'(1) << start_state);
              else
                live_set = '0;
            end else begin
              live_set = eps_closure(step_on_symbol(eps_closure(live_set), in_ch.symbol));
            end
            oldest.active_set = MASK_W'(live_set);
            oldest.accepting  = (accept_state < NUM_STATES) ? live_set[accept_state] : 1'b0;
            expected_sets.push_back(oldest);
          end
          default: ;
        endcase
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_sets.size();
    result_count  <= results_seen;
  end

endmodule

`default_nettype wire

/* tb/tb_epsilon_nfa_recognizer_top.sv */
// ----------------------------------------------------------------------------
// tb_epsilon_nfa_recognizer_top
// Drives the epsilon-NFA recognizer with a directed opening (table loads at
// the field extremes, starts and feeds through loaded and unloaded entries,
// the empty set) and then random phases that build small automata over a
// few bytes and run them, with bursty input, a receiver that stalls on its
// own pattern, one long receiver hold and several register settings. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_epsilon_nfa_recognizer_top;
  import enfa_pkg::*;

  localparam int RAND_PHASES   = 6;
  localparam int PHASE_WORDS   = 64;
  localparam int HOLD_PHASE    = 2;
  localparam int CHAIN_PHASE   = 3;
  localparam int PAUSE_PHASE   = 4;
  localparam int LONG_HOLD     = 1500;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 600;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int fail_count;
  int pending_count;
  int result_count;
  int hold_requests;

  int loads_sent;
  int starts_sent;
  int feeds_sent;
  int settings_used;
  int burst_left;

  enfa_in_if  in_ch ();
  enfa_out_if out_ch ();

  epsilon_nfa_recognizer_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  enfa_active_set_checker set_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #(64'd24_000_000);
    $display("tb_epsilon_nfa_recognizer_top failed");
    $finish;
  end

  // Receiver: change stall pattern now and then, serve long hold requests
  initial begin : receiver
    int  mode;
    int  mode_left;
    int  tick;
    int  streak_left;
    int  hold_left;
    int  holds_served;
    logic rdy;
    mode         = 0;
    mode_left    = 0;
    tick         = 0;
    streak_left  = 0;
    hold_left    = 0;
    holds_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = (tick % 5) < 3;
          default: begin
            if (streak_left != 0) begin
              streak_left--;
              rdy = 1'b0;
            end else begin
              rdy = 1'b1;
              if ($urandom_range(0, 9) == 0) streak_left = $urandom_range(5, 30);
            end
          end
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  // Sparse masks mostly, so closures do not saturate at once
  function automatic logic [MASK_W-1:0] random_mask();
    int pick;
    logic [MASK_W-1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      m = '0;
    end else if (pick < 20) begin
      m = MASK_W'($urandom);
    end else begin
      m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      if (pick >= 60) m |= MASK_W'(1) << $urandom_range(0, MASK_W - 1);
    end
    return m;
  endfunction

  // Offer one word, idling between bursts, and hold it until taken
  task automatic send_word(logic [OP_W-1:0] op, logic [STATE_FLD_W-1:0] idx,
                           logic [SYMBOL_FLD_W-1:0] sym, logic [MASK_W-1:0] mask);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) == 0) burst_left = $urandom_range(20, 60);
      else                           burst_left = $urandom_range(1, 6);
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.state_index <= idx;
    in_ch.symbol      <= sym;
    in_ch.target_mask <= mask;
    do @(posedge clk); while (!in_ch.ready);
    case (op)
      OP_START: starts_sent++;
      OP_FEED:  feeds_sent++;
      default:  loads_sent++;
    endcase
  endtask

  // Drop valid and wait until every predicted word has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges
  task automatic set_registers(logic [CFG_DATA_W-1:0] init_s, logic [CFG_DATA_W-1:0] fin_s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INITIAL_STATE;
    cfg_data  <= init_s;
    @(posedge clk);
    cfg_index <= CFG_FINAL_STATE;
    cfg_data  <= fin_s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Stimulus
  initial begin : stimulus
    logic [SYMBOL_FLD_W-1:0] alphabet [3];
    logic [SYMBOL_FLD_W-1:0] sym;
    logic [CFG_DATA_W-1:0]   init_s;
    logic [CFG_DATA_W-1:0]   fin_s;
    int                      pick;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_LOAD_SYM;
    in_ch.state_index <= '0;
    in_ch.symbol      <= '0;
    in_ch.target_mask <= '0;
    hold_requests     <= 0;
    loads_sent        = 0;
    starts_sent       = 0;
    feeds_sent        = 0;
    settings_used     = 0;
    burst_left        = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty tables, then a small cyclic automaton
    set_registers(4'd0, 4'd15);
    send_word(OP_START,    4'd0,  8'h00, 16'h0000);
    send_word(OP_FEED,     4'd0,  8'hFF, 16'h0000);
    send_word(OP_FEED,     4'd15, 8'h00, 16'hFFFF);
    send_word(OP_LOAD_SYM, 4'd0,  8'hFF, 16'hFFFF);
    send_word(OP_LOAD_SYM, 4'd15, 8'h00, 16'h8000);
    send_word(OP_LOAD_EPS, 4'd15, 8'h00, 16'h0001);
    send_word(OP_LOAD_EPS, 4'd0,  8'hFF, 16'h0002);
    send_word(OP_LOAD_EPS, 4'd1,  8'h00, 16'h0004);
    send_word(OP_START,    4'd15, 8'hFF, 16'hFFFF);
    send_word(OP_FEED,     4'd0,  8'hFF, 16'h0000);
    send_word(OP_FEED,     4'd0,  8'h00, 16'h0000);
    send_word(OP_FEED,     4'd0,  8'hAA, 16'h0000);
    send_word(OP_LOAD_SYM, 4'd10, 8'h55, 16'h5555);
    send_word(OP_LOAD_SYM, 4'd5,  8'hAA, 16'hAAAA);
    send_word(OP_LOAD_EPS, 4'd10, 8'h55, 16'h0000);
    send_word(OP_START,    4'd5,  8'h55, 16'h5555);
    wait_for_results();

    // Directed: start from the top state, accept on state zero
    set_registers(4'd15, 4'd0);
    send_word(OP_START,    4'd0,  8'h00, 16'h0000);
    send_word(OP_FEED,     4'd0,  8'hFF, 16'h0000);
    send_word(OP_FEED,     4'd0,  8'h55, 16'h0000);
    send_word(OP_FEED,     4'd0,  8'hAA, 16'h0000);
    send_word(OP_LOAD_EPS, 4'd15, 8'h00, 16'h0000);
    send_word(OP_START,    4'd0,  8'h00, 16'h0000);

    // Random phases: build automata over a small alphabet and run them
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_for_results();
      case (ph)
        0: begin
          init_s = 4'd0;
          fin_s  = 4'd0;
        end
        1: begin
          init_s = 4'd15;
          fin_s  = 4'd15;
        end
        default: begin
          init_s = CFG_DATA_W'($urandom_range(0, 15));
          fin_s  = CFG_DATA_W'($urandom_range(0, 15));
        end
      endcase
      set_registers(init_s, fin_s);
      for (int k = 0; k < 3; k++) alphabet[k] = SYMBOL_FLD_W'($urandom_range(0, 255));

      // Load an epsilon chain through every state, closing back to state zero
      if (ph == CHAIN_PHASE) begin
        for (int s = 0; s < NUM_STATES; s++)
          send_word(OP_LOAD_EPS, STATE_FLD_W'(s), SYMBOL_FLD_W'($urandom_range(0, 255)),
                    MASK_W'(1) << ((s + 1) % NUM_STATES));
      end

      // Stall the receiver while starts and feeds keep coming
      if (ph == HOLD_PHASE) hold_requests <= hold_requests + 1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        pick = $urandom_range(0, 99);
        if (ph == HOLD_PHASE) pick = 38 + pick / 2;
        if ($urandom_range(0, 7) == 0) sym = SYMBOL_FLD_W'($urandom_range(0, 255));
        else                           sym = alphabet[$urandom_range(0, 2)];
        if (pick < 28)
          send_word(OP_LOAD_SYM, STATE_FLD_W'($urandom_range(0, 15)), sym, random_mask());
        else if (pick < 38)
          send_word(OP_LOAD_EPS, STATE_FLD_W'($urandom_range(0, 15)),
                    SYMBOL_FLD_W'($urandom_range(0, 255)), random_mask());
        else if (pick < 48)
          send_word(OP_START, STATE_FLD_W'($urandom_range(0, 15)),
                    SYMBOL_FLD_W'($urandom_range(0, 255)), MASK_W'($urandom));
        else
          send_word(OP_FEED, STATE_FLD_W'($urandom_range(0, 15)), sym, MASK_W'($urandom));
        // Pause the sender mid-phase until the block has drained
        if (ph == PAUSE_PHASE && n == PHASE_WORDS / 2) wait_for_results();
      end
    end

    // Drain and give the verdict
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d loads, %0d starts and %0d feeds under %0d register settings",
             loads_sent, starts_sent, feeds_sent, settings_used);
    $display("Compared %0d result words against predicted active sets", result_count);
    if (fail_count == 0) begin
      $display("tb_epsilon_nfa_recognizer_top passed");
    end else begin
      $display("tb_epsilon_nfa_recognizer_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
